@@ src/afl_pkg.sv @@
// Package for the alternating fade flasher: field widths, phase codes,
// register indexes and reset values. No dependencies.
`default_nettype none

package afl_pkg;

  localparam int LEVEL_W = 10;
  localparam int TIME_W  = 32;
  localparam int DUR_W   = 16;
  localparam int PHASE_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [DUR_W-1:0]   dur_t;
  typedef logic [PHASE_W-1:0] phase_t;

  localparam level_t FULL_LEVEL = level_t'(1023);

  localparam phase_t PH_IDLE   = phase_t'(0);
  localparam phase_t PH_RISE   = phase_t'(1);
  localparam phase_t PH_HOLD_R = phase_t'(2);
  localparam phase_t PH_XF_L   = phase_t'(3);
  localparam phase_t PH_HOLD_L = phase_t'(4);
  localparam phase_t PH_XF_R   = phase_t'(5);
  localparam phase_t PH_FADE   = phase_t'(6);

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_POLL    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME     = 2'd2;

  localparam level_t RST_STEP_SIZE     = level_t'(32);
  localparam dur_t   RST_RAMP_INTERVAL = dur_t'(10);
  localparam dur_t   RST_HOLD_TIME     = dur_t'(500);

endpackage

`default_nettype wire

@@ src/afl_if.sv @@
// Valid/ready channel interfaces for the flasher's input and result
// transactions. Depends on afl_pkg.
`default_nettype none

interface afl_in_if;
  import afl_pkg::*;

  logic  valid;
  logic  ready;
  logic  kind;
  logic  on_request;
  time_t now_ms;

  modport source (output valid, kind, on_request, now_ms, input ready);
  modport sink   (input valid, kind, on_request, now_ms, output ready);
endinterface

interface afl_out_if;
  import afl_pkg::*;

  logic   valid;
  logic   ready;
  level_t right_level;
  level_t left_level;
  phase_t phase;
  logic   levels_written;

  modport source (output valid, right_level, left_level, phase, levels_written, input ready);
  modport sink   (input valid, right_level, left_level, phase, levels_written, output ready);
endinterface

`default_nettype wire

@@ src/alternating_fade_flasher_top.sv @@
// Latency: a result is valid the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle while the output is not stalled; the next state is one pass of add,
// compare and select logic from the phase/level/wait registers.
// Input is taken whenever the result register is empty or being drained.
// Reset (synchronous, rst_n low): idle phase, both levels 0, wait cleared,
// registers back to step 32, ramp interval 10 ms, hold 500 ms.
`default_nettype none

module alternating_fade_flasher_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  afl_in_if.sink                           in_ch,
  afl_out_if.source                        out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [afl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [afl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import afl_pkg::*;

  level_t step_size_r;
  dur_t   ramp_interval_r;
  dur_t   hold_time_r;

  phase_t phase_r,      phase_nxt;
  level_t right_r,      right_nxt;
  level_t left_r,       left_nxt;
  time_t  wait_start_r, wait_start_nxt;
  dur_t   wait_len_r,   wait_len_nxt;
  logic   written_r,    written_nxt;
  logic   out_valid_r;

  logic   in_fire;
  logic   elapsed;
  time_t  since;
  logic [LEVEL_W:0] sum;
  level_t diff;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign since   = in_ch.now_ms - wait_start_r;
  assign elapsed = since >= time_t'(wait_len_r);
  assign sum     = {1'b0, right_r} + {1'b0, step_size_r};
  assign diff    = right_r - step_size_r;

  always_comb begin
    phase_nxt      = phase_r;
    right_nxt      = right_r;
    left_nxt       = left_r;
    wait_start_nxt = wait_start_r;
    wait_len_nxt   = wait_len_r;
    written_nxt    = 1'b0;

    if (in_ch.kind == KIND_REQUEST) begin
      if (in_ch.on_request && phase_r == PH_IDLE) begin
        phase_nxt      = PH_RISE;
        wait_start_nxt = in_ch.now_ms;
        wait_len_nxt   = ramp_interval_r;
      end else if (!in_ch.on_request && phase_r >= PH_RISE && phase_r <= PH_XF_R) begin
        phase_nxt      = PH_FADE;
        wait_start_nxt = in_ch.now_ms;
        wait_len_nxt   = ramp_interval_r;
      end
    end else if (elapsed) begin
      // poll: each active phase restarts the wait, mostly with the ramp interval, except the last fade step
      wait_start_nxt = in_ch.now_ms;
      wait_len_nxt   = ramp_interval_r;
      written_nxt    = 1'b1;
      case (phase_r)
        PH_RISE: begin
          if (sum >= {1'b0, FULL_LEVEL}) begin
            right_nxt    = FULL_LEVEL;
            phase_nxt    = PH_HOLD_R;
            wait_len_nxt = hold_time_r;
          end else begin
            right_nxt = sum[LEVEL_W-1:0];
          end
        end
        PH_HOLD_R: phase_nxt = PH_XF_L;
        PH_XF_L: begin
          if (right_r > step_size_r) begin
            right_nxt = diff;
            left_nxt  = FULL_LEVEL - diff;
          end else begin
            right_nxt    = '0;
            left_nxt     = FULL_LEVEL;
            phase_nxt    = PH_HOLD_L;
            wait_len_nxt = hold_time_r;
          end
        end
        PH_HOLD_L: phase_nxt = PH_XF_R;
        PH_XF_R: begin
          if (sum >= {1'b0, FULL_LEVEL}) begin
            right_nxt    = FULL_LEVEL;
            left_nxt     = '0;
            phase_nxt    = PH_HOLD_R;
            wait_len_nxt = hold_time_r;
          end else begin
            right_nxt = sum[LEVEL_W-1:0];
            left_nxt  = FULL_LEVEL - sum[LEVEL_W-1:0];
          end
        end
        PH_FADE: begin
          right_nxt = (right_r > step_size_r) ? diff : '0;
          left_nxt  = (left_r > step_size_r) ? left_r - step_size_r : '0;
          // once both are dark the wait is left as it was
          if (right_nxt == '0 && left_nxt == '0) begin
            phase_nxt      = PH_IDLE;
            wait_start_nxt = wait_start_r;
            wait_len_nxt   = wait_len_r;
          end
        end
        default: begin
          // idle and the unused code: poll has no effect
          wait_start_nxt = wait_start_r;
          wait_len_nxt   = wait_len_r;
          written_nxt    = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r     <= RST_STEP_SIZE;
      ramp_interval_r <= RST_RAMP_INTERVAL;
      hold_time_r     <= RST_HOLD_TIME;
      phase_r         <= PH_IDLE;
      right_r         <= '0;
      left_r          <= '0;
      wait_start_r    <= '0;
      wait_len_r      <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_STEP_SIZE:     step_size_r     <= cfg_wdata[LEVEL_W-1:0];
          CFG_RAMP_INTERVAL: ramp_interval_r <= cfg_wdata[DUR_W-1:0];
          CFG_HOLD_TIME:     hold_time_r     <= cfg_wdata[DUR_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        phase_r      <= phase_nxt;
        right_r      <= right_nxt;
        left_r       <= left_nxt;
        wait_start_r <= wait_start_nxt;
        wait_len_r   <= wait_len_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // payload flag; the state registers double as the result payload since a new transaction
  // is only taken when no result is held or the held result leaves the same cycle
  always_ff @(posedge clk) begin
    if (in_fire) begin
      written_r <= written_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.right_level    = right_r;
  assign out_ch.left_level     = left_r;
  assign out_ch.phase          = phase_r;
  assign out_ch.levels_written = written_r;

endmodule

`default_nettype wire
